// ----- sv/bsim_pkg.sv -----
// Shared constants and control types for the bank switch IRQ mapper.
// No dependencies; imported by every module of the block.
package bsim_pkg;

   localparam int FRAC_BITS = 8;
   localparam int LINE_STEP = 29099;
   localparam int CNT_W = 15 + FRAC_BITS;
   localparam int SUM_W = ((CNT_W > 16) ? CNT_W : 16) + 1;
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(15'h7fff) << FRAC_BITS;

   localparam int CHR_CNT_W = 11;
   localparam int PRG_CNT_W = 9;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_STEPS = 8;

   localparam logic [CHR_CNT_W-1:0] CHR_CNT_RESET = 11'd256;
   localparam logic [PRG_CNT_W-1:0] PRG_CNT_RESET = 9'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_CHR_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_COUNT = 1'd1;

   localparam logic [1:0] OP_MAP_WRITE = 2'd0;
   localparam logic [1:0] OP_CNT_WRITE = 2'd1;
   localparam logic [1:0] OP_CNT_READ  = 2'd2;
   localparam logic [1:0] OP_TICK      = 2'd3;

   // addr[15:11] region codes
   localparam logic [4:0] RGN_CNT_LO = 5'h0a;
   localparam logic [4:0] RGN_CNT_HI = 5'h0b;
   localparam logic [4:0] RGN_PRG_0  = 5'h1c;
   localparam logic [4:0] RGN_PRG_2  = 5'h1e;
   localparam logic [1:0] RGN_CHR    = 2'b10;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ----- sv/bsim_ctrl.sv -----
// Sequencer for the mapper: accept, eight modulo steps, then result commit.
// Depends on bsim_pkg.
module bsim_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bsim_pkg::status_type status,
   output bsim_pkg::cmd_type    cmd
);
   import bsim_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;
   localparam int STEP_W = $clog2(DIV_STEPS);

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               step_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

endmodule

// ----- sv/bsim_dp.sv -----
// Datapath: page count registers, shared restoring modulo unit, IRQ counter
// and the result register. Depends on bsim_pkg.
module bsim_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  bsim_pkg::cmd_type                 cmd,
   output bsim_pkg::status_type              status,
   input  logic                              csr_we,
   input  logic [bsim_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsim_pkg::CHR_CNT_W-1:0]    csr_wdata,
   input  logic [1:0]                        req_op,
   input  logic [15:0]                       req_addr,
   input  logic [7:0]                        req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_irq_request,
   output logic                              rsp_chr_valid,
   output logic [2:0]                        rsp_chr_slot,
   output logic [7:0]                        rsp_chr_page,
   output logic                              rsp_prg_valid,
   output logic [1:0]                        rsp_prg_slot,
   output logic [5:0]                        rsp_prg_page,
   output logic                              rsp_mirror_valid,
   output logic [1:0]                        rsp_mirror_mode
);
   import bsim_pkg::*;

   logic [CHR_CNT_W-1:0] chr_cnt_ff;
   logic [PRG_CNT_W-1:0] prg_cnt_ff;

   logic [1:0]  op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;

   logic [7:0]           rem_ff, rem_in;
   logic [7:0]           dvd_ff, dvd_in;
   logic [CHR_CNT_W-1:0] dvs_ff, dvs_in;
   logic [8:0]           trial;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             en_ff, en_in;
   logic [14:0]      cnt_int;
   logic [SUM_W-1:0] cnt_sum;

   logic       out_valid_ff;
   logic [7:0] read_data_ff, read_data_in;
   logic       irq_ff, irq_in;
   logic       chr_valid_ff, chr_valid_in;
   logic [2:0] chr_slot_ff;
   logic [7:0] chr_page_ff, chr_page_in;
   logic       prg_valid_ff, prg_valid_in;
   logic [1:0] prg_slot_ff;
   logic [5:0] prg_page_ff, prg_page_in;
   logic       mir_valid_ff, mir_valid_in;
   logic [1:0] mir_mode_ff;
   logic [4:0] region;
   logic       zero_div;

   // modulo setup and one restoring step per cycle
   always_comb begin
      trial = {rem_ff, dvd_ff[7]};
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      if (cmd.capture) begin
         rem_in = '0;
         if (req_addr[15:14] == RGN_CHR) begin
            dvd_in = req_data;
            dvs_in = chr_cnt_ff;
         end else begin
            dvd_in = {2'b00, req_data[5:0]};
            dvs_in = CHR_CNT_W'(prg_cnt_ff);
         end
      end else if (cmd.div_step) begin
         dvd_in = {dvd_ff[6:0], 1'b0};
         if (CHR_CNT_W'(trial) >= dvs_ff) begin
            rem_in = 8'(CHR_CNT_W'(trial) - dvs_ff);
         end else begin
            rem_in = trial[7:0];
         end
      end
   end

   assign region = addr_ff[15:11];
   assign zero_div = (dvs_ff == '0);
   assign cnt_int = 15'(cnt_ff >> FRAC_BITS);
   assign cnt_sum = SUM_W'(cnt_ff) + SUM_W'(LINE_STEP);

   always_comb begin
      cnt_in = cnt_ff;
      en_in = en_ff;
      read_data_in = '0;
      irq_in = 1'b0;
      chr_valid_in = 1'b0;
      chr_page_in = '0;
      prg_valid_in = 1'b0;
      prg_page_in = '0;
      mir_valid_in = 1'b0;
      case (op_ff)
         OP_MAP_WRITE: begin
            if (region[4:3] == RGN_CHR) begin
               chr_valid_in = 1'b1;
               chr_page_in = zero_div ? data_ff : rem_ff;
            end else if (region >= RGN_PRG_0 && region <= RGN_PRG_2) begin
               prg_valid_in = 1'b1;
               prg_page_in = zero_div ? data_ff[5:0] : rem_ff[5:0];
               mir_valid_in = (region == RGN_PRG_0);
            end
         end
         OP_CNT_WRITE: begin
            if (region == RGN_CNT_LO) begin
               cnt_in = CNT_W'({cnt_int[14:8], data_ff}) << FRAC_BITS;
            end else if (region == RGN_CNT_HI) begin
               cnt_in = CNT_W'({data_ff[6:0], cnt_int[7:0]}) << FRAC_BITS;
               en_in = data_ff[7];
            end
         end
         OP_CNT_READ: begin
            if (region == RGN_CNT_LO) begin
               read_data_in = cnt_int[7:0];
            end else if (region == RGN_CNT_HI) begin
               read_data_in = {1'b0, cnt_int[14:8]};
            end else begin
               read_data_in = addr_ff[15:8];
            end
         end
         OP_TICK: begin
            if (en_ff) begin
               if (cnt_sum >= SUM_W'(CNT_LIMIT)) begin
                  cnt_in = CNT_LIMIT;
                  en_in = 1'b0;
                  irq_in = 1'b1;
               end else begin
                  cnt_in = CNT_W'(cnt_sum);
               end
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         chr_cnt_ff <= CHR_CNT_RESET;
         prg_cnt_ff <= PRG_CNT_RESET;
         cnt_ff <= '0;
         en_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_CHR_COUNT) begin
            chr_cnt_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_PRG_COUNT) begin
            prg_cnt_ff <= csr_wdata[PRG_CNT_W-1:0];
         end
         if (cmd.commit) begin
            cnt_ff <= cnt_in;
            en_ff <= en_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      if (cmd.capture) begin
         op_ff <= req_op;
         addr_ff <= req_addr;
         data_ff <= req_data;
      end
      if (cmd.commit) begin
         read_data_ff <= read_data_in;
         irq_ff <= irq_in;
         chr_valid_ff <= chr_valid_in;
         chr_slot_ff <= chr_valid_in ? addr_ff[13:11] : 3'd0;
         chr_page_ff <= chr_page_in;
         prg_valid_ff <= prg_valid_in;
         prg_slot_ff <= prg_valid_in ? addr_ff[12:11] : 2'd0;
         prg_page_ff <= prg_page_in;
         mir_valid_ff <= mir_valid_in;
         mir_mode_ff <= mir_valid_in ? data_ff[7:6] : 2'd0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_read_data = read_data_ff;
   assign rsp_irq_request = irq_ff;
   assign rsp_chr_valid = chr_valid_ff;
   assign rsp_chr_slot = chr_slot_ff;
   assign rsp_chr_page = chr_page_ff;
   assign rsp_prg_valid = prg_valid_ff;
   assign rsp_prg_slot = prg_slot_ff;
   assign rsp_prg_page = prg_page_ff;
   assign rsp_mirror_valid = mir_valid_ff;
   assign rsp_mirror_mode = mir_mode_ff;

endmodule

// ----- sv/bank_switch_irq_mapper.sv -----
// Top level of the bank switch IRQ mapper: sequencer plus datapath.
// Depends on bsim_pkg, bsim_ctrl and bsim_dp.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  op, addr, data
//   rsp      out        rsp_valid/rsp_ready  read_data .. mirror_mode
//   csr      in         csr_we               csr_index, csr_wdata
//
// Each word is accepted, then passes eight restoring steps of the shared
// 8-bit modulo unit and is committed to the output register. No new word
// is taken until the sequencer has returned to idle.
// A new word is accepted in the cycle after commit, even while the result
// still waits in the output register; commit waits on a held result.
// Synchronous reset restores page counts 256 and 32 and clears the counter.
module bank_switch_irq_mapper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bsim_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsim_pkg::CHR_CNT_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_op,
   input  logic [15:0]                       req_addr,
   input  logic [7:0]                        req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_irq_request,
   output logic                              rsp_chr_valid,
   output logic [2:0]                        rsp_chr_slot,
   output logic [7:0]                        rsp_chr_page,
   output logic                              rsp_prg_valid,
   output logic [1:0]                        rsp_prg_slot,
   output logic [5:0]                        rsp_prg_page,
   output logic                              rsp_mirror_valid,
   output logic [1:0]                        rsp_mirror_mode
);
   import bsim_pkg::*;

   cmd_type    cmd;
   status_type status;

   bsim_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsim_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_op           (req_op),
      .req_addr         (req_addr),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_request  (rsp_irq_request),
      .rsp_chr_valid    (rsp_chr_valid),
      .rsp_chr_slot     (rsp_chr_slot),
      .rsp_chr_page     (rsp_chr_page),
      .rsp_prg_valid    (rsp_prg_valid),
      .rsp_prg_slot     (rsp_prg_slot),
      .rsp_prg_page     (rsp_prg_page),
      .rsp_mirror_valid (rsp_mirror_valid),
      .rsp_mirror_mode  (rsp_mirror_mode)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a word while one is in flight");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not present a result");

   a_mirror_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mirror_valid) |-> (rsp_prg_valid && rsp_prg_slot == 2'd0))
      else $error("mirror update without program slot 0");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_irq_request && (rsp_chr_valid || rsp_prg_valid)))
      else $error("interrupt together with a bank update");

endmodule

// ----- tb/sv/tb_bank_switch_irq_mapper.sv -----
// Self-checking testbench for bank_switch_irq_mapper: bank writes, counter access, IRQ ticks.
// Depends on bsim_pkg and the block's RTL. Results are checked against an in-bench predictor.
module tb_bank_switch_irq_mapper;
   timeunit 1ns;
   timeprecision 1ps;

   import bsim_pkg::*;

   localparam int SETTLE_CYCLES  = 14;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_WORDS    = 107;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_request;
      logic       chr_valid;
      logic [2:0] chr_slot;
      logic [7:0] chr_page;
      logic       prg_valid;
      logic [1:0] prg_slot;
      logic [5:0] prg_page;
      logic       mirror_valid;
      logic [1:0] mirror_mode;
   } map_result_type;

   typedef struct packed {
      bus_word_type   word;
      logic           fixed;
      map_result_type want;
   } dir_row_type;

   localparam map_result_type QUIET_WORD = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CHR_CNT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_op = '0;
   logic [15:0]          req_addr = '0;
   logic [7:0]           req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [7:0]           rsp_read_data;
   logic                 rsp_irq_request;
   logic                 rsp_chr_valid;
   logic [2:0]           rsp_chr_slot;
   logic [7:0]           rsp_chr_page;
   logic                 rsp_prg_valid;
   logic [1:0]           rsp_prg_slot;
   logic [5:0]           rsp_prg_page;
   logic                 rsp_mirror_valid;
   logic [1:0]           rsp_mirror_mode;

   bank_switch_irq_mapper DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_addr         (req_addr),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq_request  (rsp_irq_request),
      .rsp_chr_valid    (rsp_chr_valid),
      .rsp_chr_slot     (rsp_chr_slot),
      .rsp_chr_page     (rsp_chr_page),
      .rsp_prg_valid    (rsp_prg_valid),
      .rsp_prg_slot     (rsp_prg_slot),
      .rsp_prg_page     (rsp_prg_page),
      .rsp_mirror_valid (rsp_mirror_valid),
      .rsp_mirror_mode  (rsp_mirror_mode)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [CHR_CNT_W-1:0] chr_pages = CHR_CNT_RESET;
   logic [PRG_CNT_W-1:0] prg_pages = PRG_CNT_RESET;
   logic [CNT_W-1:0]     line_cnt  = '0;
   logic                 line_on   = 1'b0;

   map_result_type expected_q[$];
   bus_word_type   plan_q[$];
   dir_row_type    directed_rows[$];

   int  mismatches   = 0;
   int  quiet_cycles = 0;
   int  tx_idle_pct  = 0;
   int  rx_stall_pct = 0;
   int  hold_left    = 0;
   bit  hold_req     = 1'b0;

   function automatic int page_mod(input int page, input int count);
      return (count == 0) ? page : page % count;
   endfunction

   function automatic map_result_type mapper_predict(input bus_word_type w);
      map_result_type             r;
      logic [4:0]                 rgn;
      logic [CNT_W-FRAC_BITS-1:0] whole;
      r     = QUIET_WORD;
      rgn   = w.addr[15:11];
      whole = line_cnt[CNT_W-1:FRAC_BITS];
      case (w.op)
         OP_MAP_WRITE: begin
            if (rgn[4:3] == RGN_CHR) begin
               r.chr_valid = 1'b1;
               r.chr_slot  = rgn[2:0];
               r.chr_page  = 8'(page_mod(int'(w.data), int'(chr_pages)));
            end else if (rgn >= RGN_PRG_0 && rgn <= RGN_PRG_2) begin
               r.prg_valid = 1'b1;
               r.prg_slot  = 2'(rgn - RGN_PRG_0);
               r.prg_page  = 6'(page_mod(int'(w.data[5:0]), int'(prg_pages)));
               if (rgn == RGN_PRG_0) begin
                  r.mirror_valid = 1'b1;
                  r.mirror_mode  = w.data[7:6];
               end
            end
         end
         OP_CNT_WRITE: begin
            if (rgn == RGN_CNT_LO) begin
               whole[7:0] = w.data;
               line_cnt   = CNT_W'(whole) << FRAC_BITS;
            end else if (rgn == RGN_CNT_HI) begin
               whole[14:8] = w.data[6:0];
               line_cnt    = CNT_W'(whole) << FRAC_BITS;
               line_on     = w.data[7];
            end
         end
         OP_CNT_READ: begin
            if (rgn == RGN_CNT_LO) r.read_data = whole[7:0];
            else if (rgn == RGN_CNT_HI) r.read_data = {1'b0, whole[14:8]};
            else r.read_data = w.addr[15:8];
         end
         OP_TICK: begin
            if (line_on) begin
               if (longint'(line_cnt) + LINE_STEP >= longint'(CNT_LIMIT)) begin
                  line_cnt      = CNT_LIMIT;
                  line_on       = 1'b0;
                  r.irq_request = 1'b1;
               end else begin
                  line_cnt = CNT_W'(longint'(line_cnt) + LINE_STEP);
               end
            end
         end
         default: begin
            r = QUIET_WORD;
         end
      endcase
      return r;
   endfunction

   function automatic bus_word_type random_word();
      bus_word_type w;
      w.op   = 2'($urandom);
      w.data = 8'($urandom);
      case ($urandom_range(4))
         0: w.addr = {RGN_CHR, 14'($urandom)};
         1: w.addr = {5'($urandom_range(RGN_PRG_0 - 1, RGN_PRG_2 + 1)), 11'($urandom)};
         2: w.addr = {RGN_CNT_LO[4:1], 12'($urandom)};
         default: w.addr = 16'($urandom);
      endcase
      return w;
   endfunction

   // mostly: arm the counter near its limit, tick it, read it back; rest is noise
   task automatic plan_random(input int n);
      bus_word_type w;
      int           ticks;
      plan_q.delete();
      while (plan_q.size() < n) begin
         if ($urandom_range(1) == 1) begin
            w.op   = OP_CNT_WRITE;
            w.addr = {RGN_CNT_LO, 11'($urandom)};
            w.data = 8'($urandom);
            plan_q.push_back(w);
            w.addr = {RGN_CNT_HI, 11'($urandom)};
            w.data = {($urandom_range(7) != 0),
                      ($urandom_range(7) == 0) ? 7'($urandom)
                                               : 7'($urandom_range(8'h7c, 8'h7f))};
            plan_q.push_back(w);
            ticks = $urandom_range(1, 10);
            repeat (ticks) begin
               w.op   = ($urandom_range(4) == 0) ? OP_CNT_READ : OP_TICK;
               w.addr = {($urandom_range(1) == 1) ? RGN_CNT_LO : RGN_CNT_HI, 11'($urandom)};
               w.data = 8'($urandom);
               plan_q.push_back(w);
            end
         end else begin
            repeat ($urandom_range(1, 4)) plan_q.push_back(random_word());
         end
      end
   endtask

   task automatic add_row(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                          input logic fixed, input map_result_type want);
      dir_row_type r;
      r.word  = '{op: op, addr: addr, data: data};
      r.fixed = fixed;
      r.want  = want;
      directed_rows.push_back(r);
   endtask

   task automatic offer_word(input bus_word_type w, input logic fixed,
                             input map_result_type want);
      map_result_type got;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= w.op;
      req_addr  <= w.addr;
      req_data  <= w.data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = mapper_predict(w);
      expected_q.push_back(fixed ? want : got);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CHR_CNT_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_CHR_COUNT) chr_pages = CHR_CNT_W'(value);
      else prg_pages = PRG_CNT_W'(value);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      map_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: result word with nothing expected", $time);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            check_field("read_data", want.read_data, rsp_read_data);
            check_field("irq_request", want.irq_request, rsp_irq_request);
            check_field("chr_valid", want.chr_valid, rsp_chr_valid);
            check_field("chr_slot", want.chr_slot, rsp_chr_slot);
            check_field("chr_page", want.chr_page, rsp_chr_page);
            check_field("prg_valid", want.prg_valid, rsp_prg_valid);
            check_field("prg_slot", want.prg_slot, rsp_prg_slot);
            check_field("prg_page", want.prg_page, rsp_prg_page);
            check_field("mirror_valid", want.mirror_valid, rsp_mirror_valid);
            check_field("mirror_mode", want.mirror_mode, rsp_mirror_mode);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_bank_switch_irq_mapper: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset page counts 256 / 32, counter cleared and disabled
      add_row(OP_CNT_READ,  16'h5000, 8'h00, 1'b1, '{read_data: 8'h00, default: '0});
      add_row(OP_CNT_READ,  16'h5800, 8'h00, 1'b1, '{read_data: 8'h00, default: '0});
      add_row(OP_CNT_READ,  16'hffff, 8'hff, 1'b1, '{read_data: 8'hff, default: '0});
      add_row(OP_CNT_READ,  16'h0000, 8'h00, 1'b1, '{read_data: 8'h00, default: '0});
      add_row(OP_MAP_WRITE, 16'h8000, 8'hff, 1'b1,
              '{chr_valid: 1'b1, chr_slot: 3'd0, chr_page: 8'hff, default: '0});
      add_row(OP_MAP_WRITE, 16'hbfff, 8'h00, 1'b1,
              '{chr_valid: 1'b1, chr_slot: 3'd7, chr_page: 8'h00, default: '0});
      add_row(OP_MAP_WRITE, 16'he000, 8'hff, 1'b1,
              '{prg_valid: 1'b1, prg_slot: 2'd0, prg_page: 6'd31,
                mirror_valid: 1'b1, mirror_mode: 2'd3, default: '0});
      add_row(OP_MAP_WRITE, 16'he800, 8'h40, 1'b1,
              '{prg_valid: 1'b1, prg_slot: 2'd1, prg_page: 6'd0, default: '0});
      add_row(OP_MAP_WRITE, 16'hf7ff, 8'h21, 1'b1,
              '{prg_valid: 1'b1, prg_slot: 2'd2, prg_page: 6'd1, default: '0});
      add_row(OP_MAP_WRITE, 16'hf800, 8'haa, 1'b1, QUIET_WORD);
      add_row(OP_MAP_WRITE, 16'hc000, 8'h55, 1'b1, QUIET_WORD);
      add_row(OP_TICK,      16'h0000, 8'h00, 1'b1, QUIET_WORD);
      add_row(OP_CNT_WRITE, 16'h5000, 8'hff, 1'b1, QUIET_WORD);
      add_row(OP_CNT_WRITE, 16'h5fff, 8'hff, 1'b1, QUIET_WORD);
      add_row(OP_CNT_READ,  16'h5000, 8'h00, 1'b1, '{read_data: 8'hff, default: '0});
      add_row(OP_CNT_READ,  16'h5800, 8'h00, 1'b1, '{read_data: 8'h7f, default: '0});
      add_row(OP_TICK,      16'hffff, 8'hff, 1'b1, '{irq_request: 1'b1, default: '0});
      add_row(OP_CNT_READ,  16'h5800, 8'h00, 1'b1, '{read_data: 8'h7f, default: '0});
      add_row(OP_TICK,      16'h0000, 8'h00, 1'b1, QUIET_WORD);
      add_row(OP_CNT_WRITE, 16'h4800, 8'h12, 1'b1, QUIET_WORD);
      add_row(OP_CNT_WRITE, 16'h5800, 8'h80, 1'b1, QUIET_WORD);
      add_row(OP_TICK,      16'h1234, 8'h00, 1'b0, QUIET_WORD);
      add_row(OP_CNT_READ,  16'h5000, 8'h00, 1'b0, QUIET_WORD);
      add_row(OP_CNT_WRITE, 16'h57ff, 8'h00, 1'b1, QUIET_WORD);
      add_row(OP_CNT_READ,  16'h5fff, 8'h00, 1'b0, QUIET_WORD);
      foreach (directed_rows[i])
         offer_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].want);

      for (int ph = 0; ph < 4; ph++) begin
         settle();
         case (ph)
            0: begin
               tx_idle_pct = 0;  rx_stall_pct = 0;
               write_reg(CSR_CHR_COUNT, 0);
               write_reg(CSR_PRG_COUNT, 0);
            end
            1: begin
               tx_idle_pct = 64; rx_stall_pct = 0;
               write_reg(CSR_CHR_COUNT, 2040);
               write_reg(CSR_PRG_COUNT, 510);
            end
            2: begin
               tx_idle_pct = 0;  rx_stall_pct = 64;
               hold_req = 1'b1;
               write_reg(CSR_CHR_COUNT, 1);
               write_reg(CSR_PRG_COUNT, 1);
            end
            default: begin
               tx_idle_pct = 27; rx_stall_pct = 27;
               write_reg(CSR_CHR_COUNT, $urandom_range(2, 255));
               write_reg(CSR_PRG_COUNT, $urandom_range(2, 63));
            end
         endcase
         plan_random(PHASE_WORDS);
         foreach (plan_q[i]) offer_word(plan_q[i], 1'b0, QUIET_WORD);
      end

      settle();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("tb_bank_switch_irq_mapper: PASS");
      end else begin
         $display("tb_bank_switch_irq_mapper: FAIL");
      end
      $finish;
   end

endmodule
